>>> hdl/boxds_pkg.sv
// ----------------------------------------------------------------------------
// boxds_pkg
// shared types, constants and reciprocal table for the box average downsampler
// ----------------------------------------------------------------------------
package boxds_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_RATIO = 8;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 3;
    localparam int RATIO_W     = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int ROW_W       = 12;
    localparam int ROW_XW      = 14;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_RATIO   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd2;

    localparam logic [RATIO_W-1:0]    RESET_RATIO  = 4'd1;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;

    // floor(n / (r*r)) = (n * RECIP[r]) >> DIV_SHIFT, exact for n below 2**16
    localparam int DIV_SHIFT = 24;
    localparam int RECIP_W   = 23;

    localparam logic [RECIP_W-1:0] RECIP [16] = '{
        23'd0,
        23'd0,
        23'((2**DIV_SHIFT + 3) / 4),
        23'((2**DIV_SHIFT + 8) / 9),
        23'((2**DIV_SHIFT + 15) / 16),
        23'((2**DIV_SHIFT + 24) / 25),
        23'((2**DIV_SHIFT + 35) / 36),
        23'((2**DIV_SHIFT + 48) / 49),
        23'((2**DIV_SHIFT + 63) / 64),
        23'((2**DIV_SHIFT + 80) / 81),
        23'((2**DIV_SHIFT + 99) / 100),
        23'((2**DIV_SHIFT + 120) / 121),
        23'((2**DIV_SHIFT + 143) / 144),
        23'((2**DIV_SHIFT + 168) / 169),
        23'((2**DIV_SHIFT + 195) / 196),
        23'((2**DIV_SHIFT + 224) / 225)
    };

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             row_end;
        logic             frame_end;
    } t_pixel_out;

    typedef struct packed {
        logic pass;
        logic acc;
        logic do_col;
        logic l_first;
        logic k_first;
        logic k_last;
        logic row_end;
        logic frame_end;
    } t_work_flags;

endpackage

>>> hdl/boxds_ram.sv
// ----------------------------------------------------------------------------
// boxds_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module boxds_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                         i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                         o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/boxds_queue.sv
// ----------------------------------------------------------------------------
// boxds_queue
// small register fifo between the front and back parts
// ----------------------------------------------------------------------------
module boxds_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [NW-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

>>> hdl/boxds_front.sv
// ----------------------------------------------------------------------------
// boxds_front
// configuration registers, raster position tracking and pixel classification
// ----------------------------------------------------------------------------
module boxds_front import boxds_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_RATIO = DEF_MAX_RATIO,
    parameter int AW        = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_pixel_in              i_data,
    input  logic                   i_full,
    output logic                   o_push,
    output t_work_flags            o_flags,
    output t_pixel_in              o_pixel,
    output logic [AW-1:0]          o_bc,
    output logic [RATIO_W-1:0]     o_ratio
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = $clog2(MAX_WIDTH + 64) + 1;

    logic [RATIO_W-1:0]    r_ratio;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic [CW-1:0]         r_col;
    logic [ROW_W-1:0]      r_row;
    logic [RATIO_W-1:0]    r_l;
    logic [RATIO_W-1:0]    r_k;
    logic [XW-1:0]         r_cbase;
    logic [ROW_XW-1:0]     r_rbase;
    logic [AW-1:0]         r_bc;

    logic [RATIO_W-1:0] eff_ratio;
    logic [XW-1:0]      eff_w;
    logic [ROW_XW-1:0]  eff_h;
    logic [XW-1:0]      rx;
    logic [ROW_XW-1:0]  ry;
    logic               cfg_hit;
    logic               accept;
    logic               col_last;
    logic               row_last;
    logic               l_last;
    logic               k_last;
    logic               col_ok;
    logic               row_ok;
    logic               last_bcol;
    logic               last_brow;

    always_comb begin
        if (r_ratio == '0) begin
            eff_ratio = RATIO_W'(1);
        end else if ({1'b0, r_ratio} > 5'(MAX_RATIO)) begin
            eff_ratio = RATIO_W'(MAX_RATIO);
        end else begin
            eff_ratio = r_ratio;
        end

        if (r_width == '0) begin
            eff_w = XW'(1);
        end else if (14'(r_width) > 14'(MAX_WIDTH)) begin
            eff_w = XW'(MAX_WIDTH);
        end else begin
            eff_w = XW'(r_width);
        end

        if (r_height == '0) begin
            eff_h = ROW_XW'(1);
        end else if (ROW_XW'(r_height) > ROW_XW'(HEIGHT_LIMIT)) begin
            eff_h = ROW_XW'(HEIGHT_LIMIT);
        end else begin
            eff_h = ROW_XW'(r_height);
        end
    end

    assign rx = XW'(eff_ratio);
    assign ry = ROW_XW'(eff_ratio);

    assign col_last  = (XW'(r_col) + XW'(1)) >= eff_w;
    assign row_last  = (ROW_XW'(r_row) + ROW_XW'(1)) >= eff_h;
    assign l_last    = (r_l == eff_ratio - RATIO_W'(1));
    assign k_last    = (r_k == eff_ratio - RATIO_W'(1));
    assign col_ok    = (r_cbase + rx) <= eff_w;
    assign row_ok    = (r_rbase + ry) <= eff_h;
    assign last_bcol = (r_cbase + rx + rx) > eff_w;
    assign last_brow = (r_rbase + ry + ry) > eff_h;

    assign cfg_hit = i_cfg_valid && (i_cfg_index == CFG_BLOCK_RATIO
                                     || i_cfg_index == CFG_SOURCE_WIDTH
                                     || i_cfg_index == CFG_SOURCE_HEIGHT);
    assign accept  = i_valid && !i_full;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_full;
    assign o_push      = accept;
    assign o_pixel     = i_data;
    assign o_bc        = r_bc;
    assign o_ratio     = eff_ratio;

    always_comb begin
        o_flags.pass      = (eff_ratio == RATIO_W'(1));
        o_flags.acc       = col_ok && row_ok;
        o_flags.do_col    = col_ok && row_ok && l_last;
        o_flags.l_first   = (r_l == '0);
        o_flags.k_first   = (r_k == '0);
        o_flags.k_last    = k_last;
        o_flags.row_end   = last_bcol;
        o_flags.frame_end = last_bcol && last_brow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= RESET_RATIO;
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLOCK_RATIO:   r_ratio  <= i_cfg_data[RATIO_W-1:0];
                CFG_SOURCE_WIDTH:  r_width  <= i_cfg_data;
                CFG_SOURCE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col   <= '0;
            r_row   <= '0;
            r_l     <= '0;
            r_k     <= '0;
            r_cbase <= '0;
            r_rbase <= '0;
            r_bc    <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col   <= '0;
                r_l     <= '0;
                r_cbase <= '0;
                r_bc    <= '0;
                if (row_last) begin
                    r_row   <= '0;
                    r_k     <= '0;
                    r_rbase <= '0;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                    if (k_last) begin
                        r_k     <= '0;
                        r_rbase <= r_rbase + ry;
                    end else begin
                        r_k <= r_k + RATIO_W'(1);
                    end
                end
            end else begin
                r_col <= r_col + CW'(1);
                if (l_last) begin
                    r_l     <= '0;
                    r_cbase <= r_cbase + rx;
                    r_bc    <= r_bc + AW'(1);
                end else begin
                    r_l <= r_l + RATIO_W'(1);
                end
            end
        end
    end

endmodule

>>> hdl/boxds_back.sv
// ----------------------------------------------------------------------------
// boxds_back
// row segment sums, column sum line store, block average and output register
// ----------------------------------------------------------------------------
module boxds_back import boxds_pkg::*; #(
    parameter int SUM_W = 14,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_pop,
    input  t_work_flags        i_flags,
    input  t_pixel_in          i_pixel,
    input  logic [AW-1:0]      i_bc,
    input  logic [RATIO_W-1:0] i_ratio,
    output logic               o_valid,
    input  logic               i_stall,
    output t_pixel_out         o_data
);

    localparam int PW = SUM_W + RECIP_W;

    logic [NUM_CH-1:0][SUM_W-1:0] r_partial;
    logic                         r_s1_valid;
    t_work_flags                  r_s1_flags;
    logic [AW-1:0]                r_s1_bc;
    logic                         r_s2_valid;
    logic                         r_s2_pass;
    logic                         r_s2_row_end;
    logic                         r_s2_frame_end;
    logic [NUM_CH-1:0][SUM_W-1:0] r_s2_sum;
    logic                         r_out_valid;
    t_pixel_out                   r_out;

    logic                         adv;
    logic                         ram_re;
    logic                         ram_we;
    logic [NUM_CH-1:0][SUM_W-1:0] ram_rdata;
    logic [NUM_CH-1:0][SUM_W-1:0] col_sum;
    logic [NUM_CH-1:0][SUM_W-1:0] px;
    logic [NUM_CH-1:0][PW-1:0]    prod;
    logic [NUM_CH-1:0][PIX_W-1:0] avg;
    logic [RECIP_W-1:0]           recip;
    t_pixel_out                   n_out;

    assign adv    = !r_out_valid || !i_stall;
    assign o_pop  = adv && i_q_valid;
    assign ram_re = o_pop && i_flags.do_col && !i_flags.k_first && !i_flags.pass;
    assign ram_we = adv && r_s1_valid && r_s1_flags.do_col && !r_s1_flags.pass;

    assign px[0] = SUM_W'(i_pixel.red_in);
    assign px[1] = SUM_W'(i_pixel.green_in);
    assign px[2] = SUM_W'(i_pixel.blue_in);

    boxds_ram #(
        .DATA_W (NUM_CH * SUM_W),
        .DEPTH  (DEPTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_bc),
        .i_wdata (col_sum),
        .i_re    (ram_re),
        .i_raddr (i_bc),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            col_sum[c] = r_s1_flags.k_first ? r_partial[c] : ram_rdata[c] + r_partial[c];
        end
    end

    assign recip = RECIP[i_ratio];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod[c] = PW'(r_s2_sum[c]) * PW'(recip);
            avg[c]  = r_s2_pass ? r_s2_sum[c][PIX_W-1:0] : prod[c][DIV_SHIFT +: PIX_W];
        end
        n_out.red_out   = avg[0];
        n_out.green_out = avg[1];
        n_out.blue_out  = avg[2];
        n_out.row_end   = r_s2_row_end;
        n_out.frame_end = r_s2_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.acc) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_partial[c] <= i_flags.l_first ? px[c] : r_partial[c] + px[c];
            end
        end
        if (adv) begin
            r_s1_flags     <= i_flags;
            r_s1_bc        <= i_bc;
            r_s2_sum       <= col_sum;
            r_s2_pass      <= r_s1_flags.pass;
            r_s2_row_end   <= r_s1_flags.row_end;
            r_s2_frame_end <= r_s1_flags.frame_end;
            r_out          <= n_out;
        end
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid && r_s1_flags.do_col && r_s1_flags.k_last;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hdl/box_average_downsampler.sv
// ----------------------------------------------------------------------------
// box_average_downsampler
// averages rgb pixels over ratio by ratio blocks, one result per whole block
// ----------------------------------------------------------------------------
// path: last pixel of a block -> queue -> r_s1 -> r_s2 -> r_out -> o_valid
// throughput: one pixel per cycle if the queue has room; single line store pass
// divide is a reciprocal multiply in the last stage, one per block at most
// reset: synchronous, restores block_ratio 1, width 640, height 480 and
// empties the queue and pipeline; the line store needs no clearing pass
module box_average_downsampler import boxds_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_RATIO = DEF_MAX_RATIO
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_pixel_in              i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_pixel_out             o_data
);

    localparam int SUM_DEPTH = MAX_WIDTH / 2;
    localparam int AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int SUM_W     = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1);
    localparam int FW        = $bits(t_work_flags);
    localparam int XW_PIX    = $bits(t_pixel_in);
    localparam int QW        = FW + XW_PIX + AW;

    logic               push;
    logic               full;
    logic               pop;
    logic               q_valid;
    t_work_flags        f_flags;
    t_pixel_in          f_pixel;
    logic [AW-1:0]      f_bc;
    logic [RATIO_W-1:0] ratio;
    logic [QW-1:0]      q_out;
    t_work_flags        q_flags;
    t_pixel_in          q_pixel;
    logic [AW-1:0]      q_bc;

    boxds_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RATIO (MAX_RATIO),
        .AW        (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_full      (full),
        .o_push      (push),
        .o_flags     (f_flags),
        .o_pixel     (f_pixel),
        .o_bc        (f_bc),
        .o_ratio     (ratio)
    );

    boxds_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_pixel, f_bc}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {q_flags, q_pixel, q_bc} = q_out;

    boxds_back #(
        .SUM_W (SUM_W),
        .DEPTH (SUM_DEPTH),
        .AW    (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .i_flags   (q_flags),
        .i_pixel   (q_pixel),
        .i_bc      (q_bc),
        .i_ratio   (ratio),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule
